// ===== rtl/bmd_pkg.sv =====
// Package for the 3D six-connected bitmask dilation block.
// Holds shared constants, opcodes and configuration register indices.
package bmd_pkg;
    localparam int MAX_DIM_DEF    = 64;
    localparam int MASK_BYTES_DEF = 32768;
    localparam int SIZE_W         = 7;
    localparam int ADDR_W         = 15;
    localparam int CELL_W         = 24;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
    localparam int CFG_IDX_W = 2;
endpackage

// ===== rtl/bmd_if.sv =====
// Valid/ready channel interfaces for the dilation block.
// Depends on bmd_pkg for field widths.
interface bmd_in_if import bmd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        mask_byte;
    modport source (output valid, opcode, byte_address, mask_byte, input ready);
    modport sink   (input valid, opcode, byte_address, mask_byte, output ready);
endinterface

interface bmd_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] dilated_byte;
    logic       address_error;
    modport source (output valid, dilated_byte, address_error, input ready);
    modport sink   (input valid, dilated_byte, address_error, output ready);
endinterface

interface bmd_cfg_if import bmd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [6:0]           data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bmd_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module bmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/bitmask_dilate_6_neighbour_3d_unit.sv =====
// Top level of the 3D six-connected bitmask dilation block.
// Depends on bmd_pkg, bmd_if and bmd_ram.
//
// Usage: configuration writes (size_x/y/z, index 0..2) arrive on cfg while
// idle. Input beats on in carry opcode, byte_address and mask_byte; each
// produces one beat on out. A write stores one byte. A query reads the
// byte and its neighbouring bytes one at a time through the single RAM
// port: center byte, then for each clear cell six neighbour reads.
// Locating the first cell walks whole planes, then whole rows, and a set
// cell needs no neighbour reads. An out-of-range query sets address_error
// without reading. Cell coordinates are kept as counters stepped by
// add/compare, no divider. After reset a clearing pass writes zero to every
// byte while in.ready stays low; cfg is accepted meanwhile. Sizes reset to
// MAX_DIM. When out is stalled the result is held and in.ready stays low.
module bitmask_dilate_6_neighbour_3d_unit
    import bmd_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MASK_BYTES = MASK_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bmd_cfg_if.sink   cfg,
    bmd_in_if.sink    in,
    bmd_out_if.source out
);
    localparam int AW = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
    localparam logic [CELL_W+3:0] CAP = (CELL_W+4)'(MASK_BYTES) << 3;

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_WR = 4'd2,
        S_CNT = 4'd3, S_POS = 4'd4, S_CEN = 4'd5, S_CELL = 4'd6,
        S_NRD = 4'd7, S_NCHK = 4'd8, S_OUT = 4'd9, S_CW = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [6:0] sx_reg, sy_reg, sz_reg;
    logic [CELL_W+3:0] used_reg, used_next, plane_reg, plane_next;
    logic [CELL_W+3:0] n_reg, n_next, acc_reg, acc_next;
    logic [7:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [2:0] k_reg, k_next, d_reg, d_next;
    logic [7:0] res_reg, res_next, cen_reg, cen_next;
    logic hit_reg, hit_next, err_reg, err_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0] wdat_reg;
    logic [AW:0] clr_reg, clr_next;
    logic [CELL_W+3:0] nb_reg, nb_next;
    logic nbok_reg, nbok_next;
    logic [1:0] mstep_reg, mstep_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    bmd_ram #(.WIDTH(8), .DEPTH(MASK_BYTES)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr),
        .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign cfg.ready = 1'b1;
    assign in.ready = (state_reg == S_IDLE);
    assign out.valid = (state_reg == S_OUT);
    assign out.dilated_byte = res_reg;
    assign out.address_error = err_reg;

    // Capture configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= 7'(MAX_DIM);
            sy_reg <= 7'(MAX_DIM);
            sz_reg <= 7'(MAX_DIM);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SIZE_X: sx_reg <= cfg.data;
                REG_SIZE_Y: sy_reg <= cfg.data;
                REG_SIZE_Z: sz_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Neighbour cell for direction d
    logic [CELL_W+3:0] nb_cell;
    logic              nb_in;
    always_comb
    begin
        nb_cell = n_reg;
        nb_in   = 1'b0;
        case (d_reg)
            3'd0:
            begin
                nb_cell = n_reg - 1'b1;
                nb_in   = (x_reg != 8'd0);
            end
            3'd1:
            begin
                nb_cell = n_reg + 1'b1;
                nb_in   = ({1'b0, x_reg} + 9'd1) < {2'b0, sx_reg};
            end
            3'd2:
            begin
                nb_cell = n_reg - (CELL_W+4)'(sx_reg);
                nb_in   = (y_reg != 8'd0);
            end
            3'd3:
            begin
                nb_cell = n_reg + (CELL_W+4)'(sx_reg);
                nb_in   = ({1'b0, y_reg} + 9'd1) < {2'b0, sy_reg};
            end
            3'd4:
            begin
                nb_cell = n_reg - plane_reg;
                nb_in   = (z_reg != 8'd0);
            end
            3'd5:
            begin
                nb_cell = n_reg + plane_reg;
                nb_in   = ({1'b0, z_reg} + 9'd1) < {2'b0, sz_reg};
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        used_next = used_reg;
        plane_next = plane_reg;
        n_next = n_reg;
        acc_next = acc_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        k_next = k_reg;
        d_next = d_reg;
        res_next = res_reg;
        cen_next = cen_reg;
        hit_next = hit_reg;
        err_next = err_reg;
        clr_next = clr_reg;
        nb_next = nb_reg;
        nbok_next = nbok_reg;
        mstep_next = mstep_reg;
        ram_we = 1'b0;
        ram_addr = addr_reg[AW-1:0];
        ram_wdata = wdat_reg;
        case (state_reg)
            S_CLR:
            begin
                ram_we = 1'b1;
                ram_addr = clr_reg[AW-1:0];
                ram_wdata = 8'd0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(MASK_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in.valid)
                begin
                    res_next = 8'd0;
                    if (in.opcode == OP_WRITE)
                    begin
                        err_next = ((ADDR_W+1)'(in.byte_address)
                                    >= (ADDR_W+1)'(MASK_BYTES));
                        state_next = S_WR;
                    end
                    else
                    begin
                        // plane = sx*sy, then used = plane*sz, two multiply steps
                        plane_next = (CELL_W+4)'({7'd0, sx_reg} * {7'd0, sy_reg});
                        mstep_next = 2'd0;
                        state_next = S_CNT;
                    end
                end
            end
            S_WR:
            begin
                ram_we = !err_reg;
                state_next = S_OUT;
            end
            S_CNT:
            begin
                used_next = (CELL_W+4)'({7'd0, plane_reg[13:0]} * {14'd0, sz_reg});
                if ((CELL_W+4)'({7'd0, plane_reg[13:0]} * {14'd0, sz_reg}) > CAP)
                begin
                    used_next = CAP;
                end
                n_next = (CELL_W+4)'(addr_reg) << 3;
                acc_next = '0;
                x_next = 8'd0;
                y_next = 8'd0;
                z_next = 8'd0;
                state_next = S_POS;
            end
            S_POS:
            begin
                // Walk rows: find z, y, x of n by subtracting whole planes/rows
                if (n_reg >= used_reg)
                begin
                    err_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (mstep_reg == 2'd0)
                begin
                    if (acc_reg + plane_reg <= n_reg)
                    begin
                        acc_next = acc_reg + plane_reg;
                        z_next = z_reg + 1'b1;
                    end
                    else
                    begin
                        mstep_next = 2'd1;
                    end
                end
                else if (mstep_reg == 2'd1)
                begin
                    if (acc_reg + (CELL_W+4)'(sx_reg) <= n_reg)
                    begin
                        acc_next = acc_reg + (CELL_W+4)'(sx_reg);
                        y_next = y_reg + 1'b1;
                    end
                    else
                    begin
                        x_next = 8'(n_reg - acc_reg);
                        err_next = 1'b0;
                        k_next = 3'd0;
                        state_next = S_CEN;
                    end
                end
            end
            S_CEN:
            begin
                // Center byte read issued at addr_reg; data next cycle
                state_next = S_CELL;
                mstep_next = 2'd2;
            end
            S_CELL:
            begin
                if (mstep_reg == 2'd2)
                begin
                    cen_next = ram_rdata;
                    mstep_next = 2'd3;
                end
                else if (n_reg >= used_reg || cen_reg[k_reg])
                begin
                    state_next = S_CW;
                end
                else
                begin
                    d_next = 3'd0;
                    hit_next = 1'b0;
                    state_next = S_NRD;
                end
            end
            S_NRD:
            begin
                nb_next = nb_cell;
                nbok_next = nb_in && ((nb_cell >> 3) < (CELL_W+4)'(MASK_BYTES));
                ram_addr = AW'(nb_cell >> 3);
                state_next = S_NCHK;
            end
            S_NCHK:
            begin
                if (nbok_reg && ram_rdata[nb_reg[2:0]])
                begin
                    hit_next = 1'b1;
                end
                if (d_reg == 3'd5)
                begin
                    if (hit_next)
                    begin
                        res_next = res_reg | (8'd1 << k_reg);
                    end
                    state_next = S_CW;
                end
                else
                begin
                    d_next = d_reg + 1'b1;
                    state_next = S_NRD;
                end
            end
            S_CW:
            begin
                // Advance to next cell, stepping coordinates, or finish after the byte's last cell
                if (k_reg == 3'd7 || n_reg >= used_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    n_next = n_reg + 1'b1;
                    if ({1'b0, x_reg} + 9'd1 >= {2'b0, sx_reg})
                    begin
                        x_next = 8'd0;
                        if ({1'b0, y_reg} + 9'd1 >= {2'b0, sy_reg})
                        begin
                            y_next = 8'd0;
                            z_next = z_reg + 1'b1;
                        end
                        else
                        begin
                            y_next = y_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                    state_next = S_CELL;
                end
            end
            S_OUT:
            begin
                if (out.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold input payload and register the datapath state
    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
        begin
            addr_reg <= in.byte_address;
            wdat_reg <= in.mask_byte;
        end
        used_reg <= used_next;
        plane_reg <= plane_next;
        n_reg <= n_next;
        acc_reg <= acc_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        k_reg <= k_next;
        d_reg <= d_next;
        cen_reg <= cen_next;
        hit_reg <= hit_next;
        nb_reg <= nb_next;
        nbok_reg <= nbok_next;
        res_reg <= res_next;
        err_reg <= err_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            mstep_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            mstep_reg <= mstep_next;
        end
    end

    // Result must hold while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(res_reg))
        else $error("result changed while stalled");
    // Input is never taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in.ready && out.valid))
        else $error("input and output active together");
    // Write results carry no dilation bits
    a_wr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR |=> out.dilated_byte == 8'd0)
        else $error("write result nonzero");
endmodule

// ===== test/bitmask_dilate_6_neighbour_3d_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 3D six-connected bitmask dilation unit.
// Depends on bmd_pkg, the bmd_*_if interfaces and the unit's RTL.
module bitmask_dilate_6_neighbour_3d_unit_tb;
    import bmd_pkg::*;

    localparam int STORE_BYTES = MASK_BYTES_DEF;

    typedef struct packed {
        logic [7:0] dilated;
        logic       addr_err;
    } dilation_t;

    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        bit                fixed;
        logic [7:0]        fix_byte;
        logic              fix_err;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    bmd_cfg_if cfg ();
    bmd_in_if  in ();
    bmd_out_if out ();

    bitmask_dilate_6_neighbour_3d_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .in    (in.sink),
        .out   (out.source)
    );

    // Mirror of the occupancy store and grid sizes
    logic [7:0]         grid_mask [STORE_BYTES];
    longint unsigned    dim_x = MAX_DIM_DEF;
    longint unsigned    dim_y = MAX_DIM_DEF;
    longint unsigned    dim_z = MAX_DIM_DEF;
    dilation_t          pending_q [$];
    int                 fail_count = 0;
    int                 src_idle_pct = 0;
    int                 snk_idle_pct = 0;

    // Per-beat marker that the expectation is typed into the table
    logic       beat_fixed;
    logic [7:0] beat_fix_byte;
    logic       beat_fix_err;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint unsigned grid_cells();
        longint unsigned total;
        total = dim_x * dim_y * dim_z;
        return (total < STORE_BYTES * 8) ? total : STORE_BYTES * 8;
    endfunction

    function automatic bit mask_cell(longint unsigned m);
        if ((m >> 3) >= STORE_BYTES)
            return 1'b0;
        return grid_mask[m >> 3][m & 7];
    endfunction

    // Clear cells of one byte that touch a set face neighbour inside the grid
    function automatic dilation_t grow_byte(longint unsigned a);
        dilation_t       r;
        longint unsigned used;
        longint unsigned plane;
        longint unsigned n;
        longint unsigned cx;
        longint unsigned cy;
        longint unsigned cz;
        bit              hit;
        r = '0;
        used = grid_cells();
        if (a * 8 >= used)
        begin
            r.addr_err = 1'b1;
            return r;
        end
        plane = dim_x * dim_y;
        for (int k = 0; k < 8; k++)
        begin
            n = a * 8 + k;
            if (n >= used)
                break;
            if (mask_cell(n))
                continue;
            cx = n % dim_x;
            cy = (n / dim_x) % dim_y;
            cz = n / plane;
            hit = 1'b0;
            if (cx > 0 && mask_cell(n - 1))
                hit = 1'b1;
            if (cx + 1 < dim_x && mask_cell(n + 1))
                hit = 1'b1;
            if (cy > 0 && mask_cell(n - dim_x))
                hit = 1'b1;
            if (cy + 1 < dim_y && mask_cell(n + dim_x))
                hit = 1'b1;
            if (cz > 0 && mask_cell(n - plane))
                hit = 1'b1;
            if (cz + 1 < dim_z && mask_cell(n + plane))
                hit = 1'b1;
            r.dilated[k] = hit;
        end
        return r;
    endfunction

    // Track config beats, predict on input beats, check output beats
    always @(posedge clk)
    begin
        dilation_t want;
        dilation_t got;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_SIZE_X: dim_x = cfg.data;
                REG_SIZE_Y: dim_y = cfg.data;
                REG_SIZE_Z: dim_z = cfg.data;
                default: ;
            endcase
        end
        if (in.valid && in.ready)
        begin
            if (in.opcode == OP_WRITE)
            begin
                want = '0;
                grid_mask[in.byte_address] = in.mask_byte;
            end
            else
                want = grow_byte(in.byte_address);
            if (beat_fixed)
                want = '{dilated: beat_fix_byte, addr_err: beat_fix_err};
            pending_q = {pending_q, want};
        end
        if (out.valid && out.ready)
        begin
            got = '{dilated: out.dilated_byte, addr_err: out.address_error};
            if (pending_q.size() == 0)
            begin
                $error("unexpected result beat: dilated_byte=%h address_error=%b",
                       got.dilated, got.addr_err);
                fail_count++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.dilated !== want.dilated)
                begin
                    $error("dilated_byte: expected %h, actual %h", want.dilated, got.dilated);
                    fail_count++;
                end
                if (got.addr_err !== want.addr_err)
                begin
                    $error("address_error: expected %b, actual %b",
                           want.addr_err, got.addr_err);
                    fail_count++;
                end
            end
        end
    end

    // Random backpressure on the result side
    always @(posedge clk)
        out.ready <= ($urandom_range(99) >= snk_idle_pct);

    // Send one input beat, with an optional idle gap ahead of it
    task automatic send_beat(stim_row_t row);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in.valid        <= 1'b1;
        in.opcode       <= row.op;
        in.byte_address <= row.addr;
        in.mask_byte    <= row.data;
        beat_fixed      <= row.fixed;
        beat_fix_byte   <= row.fix_byte;
        beat_fix_err    <= row.fix_err;
        do
            @(posedge clk);
        while (!in.ready);
    endtask

    // Drain the block, then load all three grid sizes back to back
    task automatic set_grid(logic [6:0] sx, logic [6:0] sy, logic [6:0] sz);
        logic [6:0]           vals [3];
        logic [CFG_IDX_W-1:0] regs [3];
        vals = '{sx, sy, sz};
        regs = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z};
        in.valid <= 1'b0;
        // Let the monitor log the last accepted beat before draining
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 3; i++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= regs[i];
            cfg.data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg.ready);
        end
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Directed table at the reset grid size of 64 cubed
    stim_row_t directed_rows [] = '{
        '{OP_QUERY, 15'd0,     8'h00, 1, 8'h00, 1'b0},
        '{OP_QUERY, 15'd32767, 8'h00, 1, 8'h00, 1'b0},
        '{OP_WRITE, 15'd0,     8'hFF, 1, 8'h00, 1'b0},
        '{OP_QUERY, 15'd0,     8'h00, 1, 8'h00, 1'b0},
        '{OP_QUERY, 15'd1,     8'h00, 0, 8'h00, 1'b0},
        '{OP_QUERY, 15'd8,     8'h00, 0, 8'h00, 1'b0},
        '{OP_QUERY, 15'd512,   8'h00, 0, 8'h00, 1'b0},
        '{OP_WRITE, 15'd7,     8'h80, 1, 8'h00, 1'b0},
        '{OP_QUERY, 15'd15,    8'h00, 0, 8'h00, 1'b0},
        '{OP_WRITE, 15'd20,    8'h55, 0, 8'h00, 1'b0},
        '{OP_QUERY, 15'd20,    8'h00, 0, 8'h00, 1'b0},
        '{OP_WRITE, 15'd32767, 8'hAA, 1, 8'h00, 1'b0},
        '{OP_QUERY, 15'd32767, 8'h00, 0, 8'h00, 1'b0},
        '{OP_QUERY, 15'd32759, 8'h00, 0, 8'h00, 1'b0},
        '{OP_QUERY, 15'd32255, 8'h00, 0, 8'h00, 1'b0},
        '{OP_WRITE, 15'd16384, 8'h01, 0, 8'h00, 1'b0},
        '{OP_QUERY, 15'd16383, 8'h00, 0, 8'h00, 1'b0},
        '{OP_QUERY, 15'd16392, 8'h00, 0, 8'h00, 1'b0}
    };

    // Grid settings walked by the random part, extremes included
    logic [6:0] phase_dims [9][3] = '{
        '{7'd64, 7'd64, 7'd64}, '{7'd3, 7'd5, 7'd7},     '{7'd1, 7'd1, 7'd1},
        '{7'd127, 7'd127, 7'd127}, '{7'd0, 7'd4, 7'd4},  '{7'd8, 7'd2, 7'd3},
        '{7'd127, 7'd1, 7'd1},  '{7'd5, 7'd127, 7'd2},   '{7'd4, 7'd4, 7'd4}
    };

    initial
    begin
        stim_row_t       row;
        longint unsigned span;
        int unsigned     window;
        rst_n           = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;
        in.valid        = 1'b0;
        in.opcode       = OP_WRITE;
        in.byte_address = '0;
        in.mask_byte    = '0;
        beat_fixed      = 1'b0;
        beat_fix_byte   = '0;
        beat_fix_err    = 1'b0;
        foreach (grid_mask[i])
            grid_mask[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        for (int p = 0; p < 9; p++)
        begin
            src_idle_pct = (p < 3) ? 34 : (p < 6) ? 74 : 0;
            snk_idle_pct = (p < 3) ? 74 : (p < 6) ? 34 : 0;
            set_grid(phase_dims[p][0], phase_dims[p][1], phase_dims[p][2]);
            span = (grid_cells() + 7) / 8;
            if (span >= STORE_BYTES)
                span = STORE_BYTES - 1;
            window = (span < 48) ? 32'(span) : 48;
            for (int i = 0; i < 50; i++)
            begin
                row.fixed    = 0;
                row.fix_byte = '0;
                row.fix_err  = 1'b0;
                row.op       = ($urandom_range(1) == 0) ? OP_WRITE : OP_QUERY;
                // Mostly cluster on the low bytes so neighbours interact
                case ($urandom_range(9))
                    0:       row.addr = ADDR_W'($urandom_range(STORE_BYTES - 1));
                    1, 2:    row.addr = ADDR_W'($urandom_range(32'(span)));
                    default: row.addr = ADDR_W'($urandom_range(window));
                endcase
                // Favor sparse bytes so dilation leaves clear cells to mark
                case ($urandom_range(3))
                    0:       row.data = 8'h01 << $urandom_range(7);
                    1:       row.data = '0;
                    default: row.data = 8'($urandom_range(255));
                endcase
                send_beat(row);
            end
        end

        in.valid <= 1'b0;
        // Let the monitor log the last accepted beat before draining
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run limit
    initial
    begin
        #30000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== bitmask_dilate_6_neighbour_3d_unit.f =====
rtl/bmd_pkg.sv
rtl/bmd_if.sv
rtl/bmd_ram.sv
rtl/bitmask_dilate_6_neighbour_3d_unit.sv
test/bitmask_dilate_6_neighbour_3d_unit_tb.sv
